### sv/frustum_cull_sphere_box_defines.svh
// assertion macros shared by the frustum cull block
`ifndef FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH
`define FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH
`ifndef SYNTHESIS
`define FCSB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcsb assertion failed");
`define FCSB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcsb assertion failed");
`else
`define FCSB_ASSERT_IMP(label, clk, rst, ante, cons)
`define FCSB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/fcsb_pkg.sv
package fcsb_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int NUM_AXES    = 3;
   localparam int COORD_W     = 22;
   localparam int COEF_W      = 14;
   localparam int RAD_W       = 21;
   localparam int FRAC_SHIFT  = 12;
   localparam int PROD_W      = COORD_W + COEF_W;
   localparam int DIST_W      = 41;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DIST_W-1:0]  dist_type;

   // matches the register packing, d in the top bits
   typedef struct packed {
      coord_type d;
      coef_type  c;
      coef_type  b;
      coef_type  a;
   } plane_type;

   typedef enum logic [1:0] {
      VERDICT_IN    = 2'd0,
      VERDICT_ISECT = 2'd1,
      VERDICT_OUT   = 2'd2
   } verdict_type;

   typedef enum logic {
      FUNC_SPHERE = 1'b0,
      FUNC_BOX    = 1'b1
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLANE_LEFT   = 3'd0,
      CSR_PLANE_RIGHT  = 3'd1,
      CSR_PLANE_TOP    = 3'd2,
      CSR_PLANE_BOTTOM = 3'd3,
      CSR_PLANE_NEAR   = 3'd4,
      CSR_PLANE_FAR    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic sph_out;
      logic sph_isec;
      logic box_allneg;
      logic box_anyneg;
   } lane_flags_type;

endpackage

### sv/frustum_cull_sphere_box.sv
// frustum cull: classifies a sphere or an axis-aligned box against six planes
//
// configuration: csr_valid/csr_ready write channel, csr_index 0..5 selects
// left, right, top, bottom, near, far; csr_data packs a,b,c (Q1.12) and d
// (Q17.4). csr_ready is always high; indexes 6 and 7 are dropped. write
// planes only while no volume is in flight.
// input: a beat is taken when start is high and busy is low. busy is low
// except during reset, so one volume can be taken every cycle.
// output: rsp_valid pulses for one cycle with rsp_verdict (0 in, 1
// intersecting, 2 out), in input order.
// throughput is one volume per cycle: six plane lanes, each a four-stage
// multiply / min-max / sum / compare pipe, feed a registered merge stage.
// the receiver cannot stall, so no buffering is needed on the output side.
// reset clears all planes to zero and drops anything in flight.
`include "frustum_cull_sphere_box_defines.svh"

module frustum_cull_sphere_box import fcsb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  logic signed [COORD_W-1:0] req_first_x,
   input  logic signed [COORD_W-1:0] req_first_y,
   input  logic signed [COORD_W-1:0] req_first_z,
   input  logic signed [COORD_W-1:0] req_second_x,
   input  logic signed [COORD_W-1:0] req_second_y,
   input  logic signed [COORD_W-1:0] req_second_z,
   input  logic [RAD_W-1:0]       req_radius,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_verdict,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PIPE_D = 4;

   logic accept;

   plane_type plane_ff [NUM_PLANES];

   logic [PIPE_D-1:0] valid_ff, valid_in;
   func_type          func_ff [PIPE_D];
   func_type          func_in [PIPE_D];
   logic [RAD_W-1:0]  radius_ff [PIPE_D-1];
   logic [RAD_W-1:0]  radius_in [PIPE_D-1];

   coord_type [NUM_AXES-1:0] lo, hi;
   lane_flags_type           flags [NUM_PLANES];
   verdict_type              verdict;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_valid && csr_ready && csr_index <= CSR_PLANE_FAR) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   // side pipe carrying the beat marker, mode and radius alongside the lanes
   always_comb begin
      valid_in   = {valid_ff[PIPE_D-2:0], accept};
      func_in[0] = func_type'(req_func);
      for (int s = 1; s < PIPE_D; s++) begin
         func_in[s] = func_ff[s-1];
      end
      radius_in[0] = req_radius;
      for (int s = 1; s < PIPE_D - 1; s++) begin
         radius_in[s] = radius_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      radius_ff <= radius_in;
   end

   assign lo = {req_first_z, req_first_y, req_first_x};
   assign hi = {req_second_z, req_second_y, req_second_x};

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
      fcsb_lane u_lane (
         .clock  (clock),
         .plane  (plane_ff[p]),
         .lo     (lo),
         .hi     (hi),
         .radius (radius_ff[PIPE_D-2]),
         .flags  (flags[p])
      );
   end

   fcsb_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .valid     (valid_ff[PIPE_D-1]),
      .func      (func_ff[PIPE_D-1]),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .verdict   (verdict)
   );

   assign rsp_verdict = verdict;

   `FCSB_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, 5))
   `FCSB_ASSERT_IMP(a_req_gets_rsp, clock, reset, start && !busy, ##5 rsp_valid)

endmodule

### sv/fcsb_lane.sv
module fcsb_lane import fcsb_pkg::*; (
   input  logic                      clock,
   input  plane_type                 plane,
   input  coord_type [NUM_AXES-1:0]  lo,
   input  coord_type [NUM_AXES-1:0]  hi,
   input  logic      [RAD_W-1:0]     radius,
   output lane_flags_type            flags
);

   coef_type [NUM_AXES-1:0] coef;

   prod_type prod_lo_ff [NUM_AXES];
   prod_type prod_hi_ff [NUM_AXES];
   prod_type prod_lo_in [NUM_AXES];
   prod_type prod_hi_in [NUM_AXES];

   prod_type tmin_ff [NUM_AXES];
   prod_type tmax_ff [NUM_AXES];
   prod_type tsph_ff [NUM_AXES];
   prod_type tmin_in [NUM_AXES];
   prod_type tmax_in [NUM_AXES];

   dist_type d_scaled;
   dist_type dmin_ff, dmax_ff, dsph_ff;
   dist_type dmin_in, dmax_in, dsph_in;

   dist_type       r_pos, r_neg;
   lane_flags_type flags_ff, flags_in;

   assign coef = {plane.c, plane.b, plane.a};

   // products for both faces of each axis
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         prod_lo_in[i] = coef[i] * lo[i];
         prod_hi_in[i] = coef[i] * hi[i];
      end
   end

   // the distance is separable, so the corner extremes come from per-axis extremes
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (prod_lo_ff[i] < prod_hi_ff[i]) begin
            tmin_in[i] = prod_lo_ff[i];
            tmax_in[i] = prod_hi_ff[i];
         end else begin
            tmin_in[i] = prod_hi_ff[i];
            tmax_in[i] = prod_lo_ff[i];
         end
      end
   end

   assign d_scaled = dist_type'($signed({plane.d, {FRAC_SHIFT{1'b0}}}));

   assign dmin_in = dist_type'(tmin_ff[0]) + dist_type'(tmin_ff[1])
                  + dist_type'(tmin_ff[2]) + d_scaled;
   assign dmax_in = dist_type'(tmax_ff[0]) + dist_type'(tmax_ff[1])
                  + dist_type'(tmax_ff[2]) + d_scaled;
   assign dsph_in = dist_type'(tsph_ff[0]) + dist_type'(tsph_ff[1])
                  + dist_type'(tsph_ff[2]) + d_scaled;

   assign r_pos = $signed({{(DIST_W-RAD_W-FRAC_SHIFT){1'b0}}, radius, {FRAC_SHIFT{1'b0}}});
   assign r_neg = -r_pos;

   always_comb begin
      flags_in.sph_out    = dsph_ff < r_neg;
      flags_in.sph_isec   = (dsph_ff < r_pos) && (dsph_ff > r_neg);
      flags_in.box_allneg = dmax_ff < 0;
      flags_in.box_anyneg = dmin_ff < 0;
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      tmin_ff    <= tmin_in;
      tmax_ff    <= tmax_in;
      tsph_ff    <= prod_lo_ff;
      dmin_ff    <= dmin_in;
      dmax_ff    <= dmax_in;
      dsph_ff    <= dsph_in;
      flags_ff   <= flags_in;
   end

   assign flags = flags_ff;

endmodule

### sv/fcsb_merge.sv
`include "frustum_cull_sphere_box_defines.svh"

module fcsb_merge import fcsb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           valid,
   input  func_type       func,
   input  lane_flags_type flags [NUM_PLANES],
   output logic           rsp_valid,
   output verdict_type    verdict
);

   verdict_type sph_verdict;
   verdict_type verdict_ff, verdict_in;
   logic        strobe_ff, strobe_in;
   logic        any_allneg, any_anyneg, any_sph;

   // first plane in list order that decides wins
   always_comb begin
      sph_verdict = VERDICT_IN;
      any_allneg  = 1'b0;
      any_anyneg  = 1'b0;
      any_sph     = 1'b0;
      for (int p = NUM_PLANES - 1; p >= 0; p--) begin
         if (flags[p].sph_out) begin
            sph_verdict = VERDICT_OUT;
         end else if (flags[p].sph_isec) begin
            sph_verdict = VERDICT_ISECT;
         end
         any_allneg = any_allneg | flags[p].box_allneg;
         any_anyneg = any_anyneg | flags[p].box_anyneg;
         any_sph    = any_sph | flags[p].sph_out | flags[p].sph_isec;
      end
   end

   always_comb begin
      priority if (func == FUNC_SPHERE) begin
         verdict_in = sph_verdict;
      end else if (any_allneg) begin
         verdict_in = VERDICT_OUT;
      end else if (any_anyneg) begin
         verdict_in = VERDICT_ISECT;
      end else begin
         verdict_in = VERDICT_IN;
      end
   end

   assign strobe_in = valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid = strobe_ff;
   assign verdict   = verdict_ff;

   `FCSB_ASSERT_NXT(a_box_out, clock, reset, valid && func == FUNC_BOX && any_allneg, rsp_valid && verdict == VERDICT_OUT)
   `FCSB_ASSERT_NXT(a_sph_in, clock, reset, valid && func == FUNC_SPHERE && !any_sph, rsp_valid && verdict == VERDICT_IN)

endmodule
